@@ src/pdmg_pkg.sv @@
// shared types and codes for the packed density matrix gate engine
package pdmg_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_GATE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  localparam logic [2:0] GK_X   = 3'd0;
  localparam logic [2:0] GK_Y   = 3'd1;
  localparam logic [2:0] GK_Z   = 3'd2;
  localparam logic [2:0] GK_H   = 3'd3;
  localparam logic [2:0] GK_S   = 3'd4;
  localparam logic [2:0] GK_SDG = 3'd5;
  localparam logic [2:0] GK_T   = 3'd6;
  localparam logic [2:0] GK_TDG = 3'd7;

  // output component of a 2x2 block
  localparam logic [2:0] SEL_R00 = 3'd0;
  localparam logic [2:0] SEL_I00 = 3'd1;
  localparam logic [2:0] SEL_R11 = 3'd2;
  localparam logic [2:0] SEL_I11 = 3'd3;
  localparam logic [2:0] SEL_R10 = 3'd4;
  localparam logic [2:0] SEL_I10 = 3'd5;
  localparam logic [2:0] SEL_R01 = 3'd6;
  localparam logic [2:0] SEL_I01 = 3'd7;

  localparam logic [2:0] QCOUNT_RESET = 3'd5;
  localparam longint SQRT_HALF_Q30 = 759250125;

  typedef logic signed [32:0] comp_t;

  typedef struct packed {
    comp_t r00;
    comp_t i00;
    comp_t r11;
    comp_t i11;
    comp_t r10;
    comp_t i10;
    comp_t r01;
    comp_t i01;
  } blk_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] sel;
    logic [2:0] kind;
    logic       conj01;
  } alu_ctl_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         sel;
    logic               sat;
    logic signed [31:0] value;
  } alu_res_t;

endpackage

@@ src/pdmg_store.sv @@
// matrix entry memory, one write port and one registered read port
module pdmg_store #(
  parameter int Depth = 528,
  parameter int Aw    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [63:0]   wdata_i,
  input  logic          re_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [63:0]   rdata_o
);
  logic [63:0] mem [Depth];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ src/pdmg_alu.sv @@
// shared three stage unit: component sum, scale, round and saturate
module pdmg_alu #(
  parameter int FRAC_BITS = 30
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pdmg_pkg::alu_ctl_t ctl_i,
  input  pdmg_pkg::blk_t     blk_i,
  output pdmg_pkg::alu_res_t res_o
);
  import pdmg_pkg::*;

  localparam int Sh = 30 - FRAC_BITS;
  localparam longint KVal = (SQRT_HALF_Q30 + ((longint'(1) << Sh) >>> 1)) >>> Sh;
  localparam logic [1:0] MD_PASS = 2'd0;
  localparam logic [1:0] MD_HALF = 2'd1;
  localparam logic [1:0] MD_MUL  = 2'd2;

  typedef struct packed {
    logic signed [34:0] s;
    logic [1:0]         mode;
  } sum_t;

  function automatic sum_t comp_sum(input logic [2:0] kind, input logic [2:0] sel,
                                    input blk_t b);
    logic signed [34:0] r00, i00, r11, i11, r10, i10, r01, i01;
    sum_t o;
    r00 = 35'(b.r00); i00 = 35'(b.i00);
    r11 = 35'(b.r11); i11 = 35'(b.i11);
    r10 = 35'(b.r10); i10 = 35'(b.i10);
    r01 = 35'(b.r01); i01 = 35'(b.i01);
    o.mode = (kind == GK_H) ? MD_HALF : MD_PASS;
    o.s = '0;
    case (sel)
      SEL_R00: begin
        case (kind)
          GK_X, GK_Y: o.s = r11;
          GK_H:       o.s = r00 + r01 + r10 + r11;
          default:    o.s = r00;
        endcase
      end
      SEL_I00: begin
        case (kind)
          GK_X, GK_Y: o.s = i11;
          GK_H:       o.s = i00 + i01 + i10 + i11;
          default:    o.s = i00;
        endcase
      end
      SEL_R11: begin
        case (kind)
          GK_X, GK_Y: o.s = r00;
          GK_H:       o.s = r00 - r01 - r10 + r11;
          default:    o.s = r11;
        endcase
      end
      SEL_I11: begin
        case (kind)
          GK_X, GK_Y: o.s = i00;
          GK_H:       o.s = i00 - i01 - i10 + i11;
          default:    o.s = i11;
        endcase
      end
      SEL_R10: begin
        case (kind)
          GK_X:    o.s = r01;
          GK_Y:    o.s = -r01;
          GK_Z:    o.s = -r10;
          GK_H:    o.s = r00 + r01 - r10 - r11;
          GK_S:    o.s = -i10;
          GK_SDG:  o.s = i10;
          GK_T:    o.s = r10 - i10;
          default: o.s = r10 + i10;
        endcase
      end
      SEL_I10: begin
        case (kind)
          GK_X:    o.s = i01;
          GK_Y:    o.s = -i01;
          GK_Z:    o.s = -i10;
          GK_H:    o.s = i00 + i01 - i10 - i11;
          GK_S:    o.s = r10;
          GK_SDG:  o.s = -r10;
          GK_T:    o.s = r10 + i10;
          default: o.s = i10 - r10;
        endcase
      end
      SEL_R01: begin
        case (kind)
          GK_X:    o.s = r10;
          GK_Y:    o.s = -r10;
          GK_Z:    o.s = -r01;
          GK_H:    o.s = r00 - r01 + r10 - r11;
          GK_S:    o.s = i01;
          GK_SDG:  o.s = -i01;
          GK_T:    o.s = r01 + i01;
          default: o.s = r01 - i01;
        endcase
      end
      default: begin
        case (kind)
          GK_X:    o.s = i10;
          GK_Y:    o.s = -i10;
          GK_Z:    o.s = -i01;
          GK_H:    o.s = i00 - i01 + i10 - i11;
          GK_S:    o.s = -r01;
          GK_SDG:  o.s = r01;
          GK_T:    o.s = i01 - r01;
          default: o.s = r01 + i01;
        endcase
      end
    endcase
    if ((kind == GK_T || kind == GK_TDG) && sel[2]) begin
      o.mode = MD_MUL;
    end
    return o;
  endfunction

  sum_t               sum_c;
  logic signed [34:0] s1_q;
  logic [1:0]         mode1_q;
  logic               v1_q, v2_q;
  logic [2:0]         sel1_q, sel2_q;
  logic signed [66:0] p2_d, p2_q;
  logic signed [67:0] rnd;
  logic signed [67:0] shr;
  logic signed [31:0] k_c;
  alu_res_t           res_d, res_q;

  assign k_c = 32'(KVal);

  always_comb begin
    sum_c = comp_sum(ctl_i.kind, ctl_i.sel, blk_i);
    // stored mirror of an upper entry takes the conjugate
    if (ctl_i.conj01 && ctl_i.sel == SEL_I01) begin
      sum_c.s = -sum_c.s;
    end
  end

  always_comb begin
    case (mode1_q)
      MD_MUL:  p2_d = 67'(s1_q) * 67'(k_c);
      MD_HALF: p2_d = 67'(s1_q) <<< (FRAC_BITS - 1);
      default: p2_d = 67'(s1_q) <<< FRAC_BITS;
    endcase
  end

  // round half away from zero, then clip to 32 bits
  always_comb begin
    rnd = 68'(p2_q) + (68'sd1 <<< (FRAC_BITS - 1)) - (p2_q < 0 ? 68'sd1 : 68'sd0);
    shr = rnd >>> FRAC_BITS;
    res_d.valid = v2_q;
    res_d.sel   = sel2_q;
    res_d.sat   = 1'b0;
    if (shr > 68'sd2147483647) begin
      res_d.value = 32'sh7fffffff;
      res_d.sat   = 1'b1;
    end else if (shr < -68'sd2147483648) begin
      res_d.value = 32'sh80000000;
      res_d.sat   = 1'b1;
    end else begin
      res_d.value = shr[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      res_q <= '0;
    end else begin
      v1_q  <= ctl_i.valid;
      v2_q  <= v1_q;
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q    <= sum_c.s;
    mode1_q <= sum_c.mode;
    sel1_q  <= ctl_i.sel;
    p2_q    <= p2_d;
    sel2_q  <= sel1_q;
  end

  assign res_o = res_q;
endmodule

@@ src/packed_density_matrix_gate_engine_unit.sv @@
// top level: sequencer for entry access and gate sweeps over the packed matrix
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  item in  | start_i, busy_o       | operation, element_index, write_real/imag,
//           |                       | gate_kind, target_qubit
//  result   | done_o (one cycle)    | read_real_o, read_imag_o, status_o
//  config   | cfg_we_i              | cfg_wdata_i (qubit count)
//
// a gate sweeps the blocks one at a time, reading, computing and writing three
// entries per diagonal block and four per off-diagonal block, set by the single
// memory port and the one shared sum/scale/round unit.
// the memory is not cleared at reset; results cannot be stalled.
module packed_density_matrix_gate_engine_unit #(
  parameter int MAX_QUBITS = 5,
  parameter int FRAC_BITS  = 30
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         operation_i,
  input  logic [9:0]         element_index_i,
  input  logic signed [31:0] write_real_i,
  input  logic signed [31:0] write_imag_i,
  input  logic [2:0]         gate_kind_i,
  input  logic [2:0]         target_qubit_i,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  output logic               done_o,
  output logic signed [31:0] read_real_o,
  output logic signed [31:0] read_imag_o,
  output logic [1:0]         status_o
);
  import pdmg_pkg::*;

  localparam int Rw    = MAX_QUBITS;
  localparam int DimMx = 1 << MAX_QUBITS;
  localparam int Depth = DimMx * (DimMx + 1) / 2;
  localparam int Aw    = $clog2(Depth);
  localparam int Nqw   = $clog2(MAX_QUBITS + 1);
  localparam int Sw    = 2 * MAX_QUBITS + 1;
  localparam int Cw    = (Sw > 10) ? Sw : 10;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RWAIT = 3'd2;
  localparam logic [2:0] S_GRD   = 3'd3;
  localparam logic [2:0] S_GCALC = 3'd4;
  localparam logic [2:0] S_GWR   = 3'd5;

  function automatic logic [Rw-1:0] zero_bit(input logic [Rw-1:0] v, input logic [2:0] t);
    logic [Rw-1:0] m;
    m = (Rw'(1) << t) - Rw'(1);
    return (v & m) | ((v & ~m) << 1);
  endfunction

  function automatic logic [Aw-1:0] pack_at(input logic [Rw:0] dim, input logic [Rw-1:0] r,
                                            input logic [Rw-1:0] c);
    logic [Rw+1:0]   span;
    logic [2*Rw+3:0] prod;
    logic [2*Rw+3:0] idx;
    span = {dim, 1'b0} - (Rw+2)'(c) + (Rw+2)'(1);
    prod = (2*Rw+4)'(c) * (2*Rw+4)'(span);
    idx  = (prod >> 1) + (2*Rw+4)'(r) - (2*Rw+4)'(c);
    return idx[Aw-1:0];
  endfunction

  logic [2:0]         state_q, state_d;
  logic [2:0]         cfg_q;
  logic [Nqw-1:0]     nq_c, nq_q;
  logic [1:0]         op_q;
  logic [9:0]         idx_q;
  logic [31:0]        wre_q, wim_q;
  logic [2:0]         kind_q, tq_q;
  logic [Rw-1:0]      bc_q, br_q;
  logic [3:0]         step_q;
  logic               sat_q;
  logic [63:0]        a_q [4];
  logic [31:0]        n_q [8];
  logic [Aw-1:0]      addr_q [4];
  logic               done_q;
  logic signed [31:0] rre_q, rim_q;
  logic [1:0]         stat_q;

  logic [Rw:0]        dim, half;
  logic [Sw-1:0]      size;
  logic [Rw-1:0]      c0, c1, r0, r1, pr, pc;
  logic               lower, diag;
  logic [3:0]         nrd, ncomp, nwr;
  logic [Aw+9:0]      idx_wide;
  logic [Aw-1:0]      idx_a, gaddr;
  logic               mem_we, mem_re;
  logic [Aw-1:0]      mem_wa, mem_ra;
  logic [63:0]        mem_wd, mem_rd;
  alu_ctl_t           actl;
  blk_t               blk;
  alu_res_t           ares;
  logic [1:0]         slot, wslot;

  always_comb begin
    if (cfg_q == 3'd0) begin
      nq_c = Nqw'(1);
    end else if (int'(cfg_q) > MAX_QUBITS) begin
      nq_c = Nqw'(MAX_QUBITS);
    end else begin
      nq_c = Nqw'(cfg_q);
    end
  end

  assign dim      = (Rw+1)'(1) << nq_q;
  assign half     = dim >> 1;
  assign size     = Sw'(dim + (Rw+1)'(1)) << (nq_q - Nqw'(1));
  assign idx_wide = {{Aw{1'b0}}, idx_q};
  assign idx_a    = idx_wide[Aw-1:0];

  assign c0    = zero_bit(bc_q, tq_q);
  assign c1    = c0 | (Rw'(1) << tq_q);
  assign r0    = zero_bit(br_q, tq_q);
  assign r1    = r0 | (Rw'(1) << tq_q);
  assign lower = r0 >= c1;
  assign diag  = bc_q == br_q;
  assign nrd   = diag ? 4'd3 : 4'd4;
  assign ncomp = diag ? 4'd6 : 4'd8;
  assign nwr   = diag ? 4'd3 : 4'd4;
  assign slot  = step_q[1:0] - 2'd1;
  assign wslot = step_q[1:0];

  // entry order in a block: 00, 11, 10, then the 01 entry or its mirror
  always_comb begin
    case (step_q[1:0])
      2'd0:    begin pr = r0; pc = c0; end
      2'd1:    begin pr = r1; pc = c1; end
      2'd2:    begin pr = r1; pc = c0; end
      default: begin pr = lower ? r0 : c1; pc = lower ? c1 : r0; end
    endcase
  end
  assign gaddr = pack_at(dim, pr, pc);

  always_comb begin
    blk.r00 = 33'(signed'(a_q[0][63:32]));
    blk.i00 = 33'(signed'(a_q[0][31:0]));
    blk.r11 = 33'(signed'(a_q[1][63:32]));
    blk.i11 = 33'(signed'(a_q[1][31:0]));
    blk.r10 = 33'(signed'(a_q[2][63:32]));
    blk.i10 = 33'(signed'(a_q[2][31:0]));
    if (diag) begin
      blk.r01 = blk.r10;
      blk.i01 = -blk.i10;
    end else if (lower) begin
      blk.r01 = 33'(signed'(a_q[3][63:32]));
      blk.i01 = 33'(signed'(a_q[3][31:0]));
    end else begin
      blk.r01 = 33'(signed'(a_q[3][63:32]));
      blk.i01 = -33'(signed'(a_q[3][31:0]));
    end
    actl.valid  = (state_q == S_GCALC) && (step_q < ncomp);
    actl.sel    = step_q[2:0];
    actl.kind   = kind_q;
    actl.conj01 = !diag && !lower;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_a;
    mem_wd = {wre_q, wim_q};
    mem_re = 1'b0;
    mem_ra = idx_a;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
        if (op_q == OP_WRITE && Cw'(idx_q) < Cw'(size)) begin
          mem_we = 1'b1;
        end else if (op_q == OP_READ && Cw'(idx_q) < Cw'(size)) begin
          mem_re  = 1'b1;
          state_d = S_RWAIT;
        end else if (op_q == OP_GATE && int'(tq_q) < int'(nq_q)) begin
          state_d = S_GRD;
        end
      end
      S_RWAIT: state_d = S_IDLE;
      S_GRD: begin
        mem_re = step_q < nrd;
        mem_ra = gaddr;
        if (step_q == nrd) state_d = S_GCALC;
      end
      S_GCALC: begin
        if (ares.valid && ares.sel == 3'(ncomp - 4'd1)) state_d = S_GWR;
      end
      S_GWR: begin
        mem_we = 1'b1;
        mem_wa = addr_q[wslot];
        mem_wd = {n_q[{wslot, 1'b0}], n_q[{wslot, 1'b1}]};
        if (step_q == nwr - 4'd1) begin
          if ((Rw+1)'(br_q) + (Rw+1)'(1) < half || (Rw+1)'(bc_q) + (Rw+1)'(1) < half) begin
            state_d = S_GRD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cfg_q   <= QCOUNT_RESET;
      done_q  <= 1'b0;
      step_q  <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (cfg_we_i) cfg_q <= cfg_wdata_i;
      case (state_q)
        S_EXEC: begin
          step_q <= '0;
          sat_q  <= 1'b0;
          if (state_d == S_IDLE) done_q <= 1'b1;
        end
        S_RWAIT: done_q <= 1'b1;
        S_GRD: begin
          step_q <= (step_q == nrd) ? 4'd0 : step_q + 4'd1;
        end
        S_GCALC: begin
          if (state_d == S_GWR) begin
            step_q <= '0;
          end else if (step_q < ncomp) begin
            step_q <= step_q + 4'd1;
          end
          if (ares.valid && ares.sat) sat_q <= 1'b1;
        end
        S_GWR: begin
          step_q <= (state_d == S_GWR) ? step_q + 4'd1 : 4'd0;
          if (state_d == S_IDLE) done_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      op_q   <= operation_i;
      idx_q  <= element_index_i;
      wre_q  <= write_real_i;
      wim_q  <= write_imag_i;
      kind_q <= gate_kind_i;
      tq_q   <= target_qubit_i;
      nq_q   <= nq_c;
    end
    if (state_q == S_EXEC) begin
      bc_q   <= '0;
      br_q   <= '0;
      rre_q  <= '0;
      rim_q  <= '0;
      stat_q <= (state_d == S_IDLE && !(op_q == OP_WRITE && Cw'(idx_q) < Cw'(size)))
                ? ST_RANGE : ST_OK;
    end
    if (state_q == S_RWAIT) begin
      rre_q  <= signed'(mem_rd[63:32]);
      rim_q  <= signed'(mem_rd[31:0]);
      stat_q <= ST_OK;
    end
    if (state_q == S_GRD) begin
      if (step_q < nrd) addr_q[step_q[1:0]] <= gaddr;
      if (step_q != 4'd0) a_q[slot] <= mem_rd;
    end
    if (state_q == S_GCALC && ares.valid) begin
      n_q[ares.sel] <= ares.value;
    end
    if (state_q == S_GWR && step_q == nwr - 4'd1) begin
      if ((Rw+1)'(br_q) + (Rw+1)'(1) < half) begin
        br_q <= br_q + Rw'(1);
      end else begin
        bc_q <= bc_q + Rw'(1);
        br_q <= bc_q + Rw'(1);
      end
      stat_q <= sat_q ? ST_SAT : ST_OK;
    end
  end

  pdmg_store #(
    .Depth(Depth),
    .Aw   (Aw)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_wa),
    .wdata_i(mem_wd),
    .re_i   (mem_re),
    .raddr_i(mem_ra),
    .rdata_o(mem_rd)
  );

  pdmg_alu #(
    .FRAC_BITS(FRAC_BITS)
  ) u_alu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (actl),
    .blk_i (blk),
    .res_o (ares)
  );

  assign busy_o      = state_q != S_IDLE;
  assign done_o      = done_q;
  assign read_real_o = rre_q;
  assign read_imag_o = rim_q;
  assign status_o    = stat_q;
endmodule

@@ src/pdmg_checker.sv @@
// port level checks for the gate engine, bound to the top level
module pdmg_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic signed [31:0] read_real_o,
  input logic signed [31:0] read_imag_o,
  input logic [1:0]         status_o
);
  import pdmg_pkg::*;

  // an accepted beat always occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted beat did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && !$past(done_o))
    else $error("result strobe while busy or repeated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> read_real_o == 0 && read_imag_o == 0)
    else $error("nonzero read data with error status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o == ST_OK || status_o == ST_RANGE || status_o == ST_SAT)
    else $error("undefined status code");
endmodule

bind packed_density_matrix_gate_engine_unit pdmg_checker u_pdmg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .read_real_o(read_real_o),
  .read_imag_o(read_imag_o),
  .status_o   (status_o)
);
